>>> rtl/zae_pkg.sv
// Shared types, codes and reset constants for the zone alarm escalation block.
package zae_pkg;

    // Zone state encoding as seen on the result channel.
    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_WARNING = 2'd1,
        ST_ALARM   = 2'd2,
        ST_LINKAGE = 2'd3
    } t_zone_state;

    // Reason codes in priority order; RC_INIT marks "no change since reset".
    typedef enum logic [3:0] {
        RC_CLEAR     = 4'd0,
        RC_HOLD      = 4'd1,
        RC_PERSISTED = 4'd2,
        RC_FLAME     = 4'd3,
        RC_GAS       = 4'd4,
        RC_TEMP      = 4'd5,
        RC_COMBINED  = 4'd6,
        RC_GASWARN   = 4'd7,
        RC_TEMPWARN  = 4'd8,
        RC_INIT      = 4'd9
    } t_reason_code;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAS_WARN      = 3'd0,
        CFG_GAS_ALARM     = 3'd1,
        CFG_TEMP_WARN     = 3'd2,
        CFG_TEMP_ALARM    = 3'd3,
        CFG_WARN_PERSIST  = 3'd4,
        CFG_ALARM_PERSIST = 3'd5,
        CFG_RELAY_HOLD    = 3'd6
    } t_cfg_idx;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Bit positions inside reason_bits.
    localparam int RB_GASWARN   = 0;
    localparam int RB_TEMPWARN  = 1;
    localparam int RB_GASALARM  = 2;
    localparam int RB_TEMPALARM = 3;
    localparam int RB_FLAME     = 4;
    localparam int RB_COMBINED  = 5;
    localparam int RB_PERSISTED = 6;
    localparam int RB_HOLD      = 7;

    // Register reset values.
    localparam logic [15:0]        RST_GAS_WARN      = 16'd300;
    localparam logic [15:0]        RST_GAS_ALARM     = 16'd600;
    localparam logic signed [11:0] RST_TEMP_WARN     = 12'sd450;
    localparam logic signed [11:0] RST_TEMP_ALARM    = 12'sd600;
    localparam logic [31:0]        RST_WARN_PERSIST  = 32'd3000;
    localparam logic [31:0]        RST_ALARM_PERSIST = 32'd5000;
    localparam logic [31:0]        RST_RELAY_HOLD    = 32'd10000;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0] gas_warn;
        logic [15:0] gas_alarm;
        logic [11:0] temp_warn;
        logic [11:0] temp_alarm;
        logic [31:0] warn_persist;
        logic [31:0] alarm_persist;
        logic [31:0] relay_hold;
    } t_cfg;

    // Threshold flags of one sample.
    typedef struct packed {
        logic gas_warn;
        logic temp_warn;
        logic gas_alarm;
        logic temp_alarm;
        logic flame;
    } t_reason;

    // One result beat.
    typedef struct packed {
        t_zone_state  zone_state;
        t_zone_state  prior_state;
        logic         state_changed;
        logic         buzzer_on;
        logic         relay_on;
        logic [7:0]   reason_bits;
        t_reason_code reason_code;
        t_reason_code transition_code;
        logic [31:0]  alarm_start_ms;
        logic [31:0]  linkage_start_ms;
        logic [31:0]  last_change_ms;
    } t_result;

endpackage

>>> rtl/zae_cfg_regs.sv
// Configuration register file with reset values and write decode.
module zae_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [zae_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [zae_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output zae_pkg::t_cfg                     o_cfg
);
    import zae_pkg::*;

    t_cfg r_cfg;

    // Writes to unused indexes fall through and change nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gas_warn      <= RST_GAS_WARN;
            r_cfg.gas_alarm     <= RST_GAS_ALARM;
            r_cfg.temp_warn     <= RST_TEMP_WARN;
            r_cfg.temp_alarm    <= RST_TEMP_ALARM;
            r_cfg.warn_persist  <= RST_WARN_PERSIST;
            r_cfg.alarm_persist <= RST_ALARM_PERSIST;
            r_cfg.relay_hold    <= RST_RELAY_HOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GAS_WARN:      r_cfg.gas_warn      <= i_cfg_wdata[15:0];
                CFG_GAS_ALARM:     r_cfg.gas_alarm     <= i_cfg_wdata[15:0];
                CFG_TEMP_WARN:     r_cfg.temp_warn     <= i_cfg_wdata[11:0];
                CFG_TEMP_ALARM:    r_cfg.temp_alarm    <= i_cfg_wdata[11:0];
                CFG_WARN_PERSIST:  r_cfg.warn_persist  <= i_cfg_wdata;
                CFG_ALARM_PERSIST: r_cfg.alarm_persist <= i_cfg_wdata;
                CFG_RELAY_HOLD:    r_cfg.relay_hold    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/zae_classify.sv
// Threshold comparisons that turn one sensor sample into reason flags.
module zae_classify (
    input  logic [15:0]        i_gas_level,
    input  logic               i_gas_valid,
    input  logic signed [11:0] i_temperature,
    input  logic               i_temp_valid,
    input  logic               i_flame_seen,
    input  zae_pkg::t_cfg      i_cfg,
    output zae_pkg::t_reason   o_reason
);
    import zae_pkg::*;

    // A reading with its valid bit clear raises nothing.
    always_comb begin
        o_reason.gas_warn   = i_gas_valid && (i_gas_level >= i_cfg.gas_warn);
        o_reason.gas_alarm  = i_gas_valid && (i_gas_level >= i_cfg.gas_alarm);
        o_reason.temp_warn  = i_temp_valid &&
                              ($signed(i_temperature) >= $signed(i_cfg.temp_warn));
        o_reason.temp_alarm = i_temp_valid &&
                              ($signed(i_temperature) >= $signed(i_cfg.temp_alarm));
        o_reason.flame      = i_flame_seen;
    end

endmodule

>>> rtl/zae_fsm.sv
// Escalation state machine: timers, next state, reason code and result beat.
module zae_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  zae_pkg::t_reason   i_reason,
    input  logic [31:0]        i_now_ms,
    input  zae_pkg::t_cfg      i_cfg,
    output zae_pkg::t_result   o_result
);
    import zae_pkg::*;

    t_zone_state  r_state,        n_state;
    logic [31:0]  r_warn_since,   n_warn_since;
    logic [31:0]  r_alarm_since,  n_alarm_since;
    logic [31:0]  r_link_since,   n_link_since;
    logic [31:0]  r_changed_at,   n_changed_at;
    t_reason_code r_last_trans,   n_last_trans;

    logic        warn;
    logic        alarm;
    logic        hold;
    logic        persisted;
    logic        warn_due;
    logic [31:0] link_elapsed;
    logic [31:0] alarm_elapsed;
    logic [31:0] warn_elapsed;
    logic [7:0]  bits;
    t_reason_code code;

    // Condition summary and start-time arming; zero means not armed.
    always_comb begin
        warn  = i_reason.gas_warn || i_reason.temp_warn;
        alarm = i_reason.flame || i_reason.gas_alarm || i_reason.temp_alarm ||
                (i_reason.gas_warn && i_reason.temp_warn);
        n_warn_since  = !warn ? 32'd0 :
                        (r_warn_since == 32'd0) ? i_now_ms : r_warn_since;
        n_alarm_since = !alarm ? 32'd0 :
                        (r_alarm_since == 32'd0) ? i_now_ms : r_alarm_since;
        link_elapsed  = i_now_ms - r_link_since;
        alarm_elapsed = i_now_ms - n_alarm_since;
        warn_elapsed  = i_now_ms - n_warn_since;
        hold      = (r_state == ST_LINKAGE) && !alarm && (r_link_since != 32'd0) &&
                    (link_elapsed < i_cfg.relay_hold);
        persisted = alarm && (n_alarm_since != 32'd0) &&
                    (alarm_elapsed >= i_cfg.alarm_persist);
        warn_due  = warn && (n_warn_since != 32'd0) &&
                    (warn_elapsed >= i_cfg.warn_persist);
    end

    // Next state.
    always_comb begin
        priority if (hold) begin
            n_state = ST_LINKAGE;
        end else if (alarm) begin
            n_state = persisted ? ST_LINKAGE : ST_ALARM;
        end else if (warn_due) begin
            n_state = ST_WARNING;
        end else begin
            n_state = ST_NORMAL;
        end
    end

    // Reason bits and the top-priority reason code.
    always_comb begin
        bits = '0;
        bits[RB_GASWARN]   = i_reason.gas_warn;
        bits[RB_TEMPWARN]  = i_reason.temp_warn;
        bits[RB_GASALARM]  = i_reason.gas_alarm;
        bits[RB_TEMPALARM] = i_reason.temp_alarm;
        bits[RB_FLAME]     = i_reason.flame;
        bits[RB_COMBINED]  = i_reason.gas_warn && i_reason.temp_warn;
        bits[RB_PERSISTED] = persisted && !hold;
        bits[RB_HOLD]      = hold;
        priority if (bits[RB_HOLD])           code = RC_HOLD;
        else if (bits[RB_PERSISTED])          code = RC_PERSISTED;
        else if (bits[RB_FLAME])              code = RC_FLAME;
        else if (bits[RB_GASALARM])           code = RC_GAS;
        else if (bits[RB_TEMPALARM])          code = RC_TEMP;
        else if (bits[RB_COMBINED])           code = RC_COMBINED;
        else if (bits[RB_GASWARN])            code = RC_GASWARN;
        else if (bits[RB_TEMPWARN])           code = RC_TEMPWARN;
        else                                  code = RC_CLEAR;
    end

    // Timestamps that follow the state change, and the result beat.
    always_comb begin
        if ((n_state == ST_LINKAGE) && (r_state != ST_LINKAGE)) begin
            n_link_since = i_now_ms;
        end else if ((n_state != ST_LINKAGE) && !hold && !alarm) begin
            n_link_since = 32'd0;
        end else begin
            n_link_since = r_link_since;
        end
        if (n_state != r_state) begin
            n_changed_at = i_now_ms;
            n_last_trans = code;
        end else begin
            n_changed_at = r_changed_at;
            n_last_trans = r_last_trans;
        end
        o_result.zone_state       = n_state;
        o_result.prior_state      = r_state;
        o_result.state_changed    = (n_state != r_state);
        o_result.buzzer_on        = (n_state == ST_ALARM) || (n_state == ST_LINKAGE);
        o_result.relay_on         = (n_state == ST_LINKAGE);
        o_result.reason_bits      = bits;
        o_result.reason_code      = code;
        o_result.transition_code  = n_last_trans;
        o_result.alarm_start_ms   = n_alarm_since;
        o_result.linkage_start_ms = n_link_since;
        o_result.last_change_ms   = n_changed_at;
    end

    // State registers move only when a sample is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_NORMAL;
            r_warn_since  <= 32'd0;
            r_alarm_since <= 32'd0;
            r_link_since  <= 32'd0;
            r_changed_at  <= 32'd0;
            r_last_trans  <= RC_INIT;
        end else if (i_step) begin
            r_state       <= n_state;
            r_warn_since  <= n_warn_since;
            r_alarm_since <= n_alarm_since;
            r_link_since  <= n_link_since;
            r_changed_at  <= n_changed_at;
            r_last_trans  <= n_last_trans;
        end
    end

endmodule

>>> rtl/zone_alarm_escalation_fsm_unit.sv
// Top level of the zone alarm escalation block.
// One sensor sample goes in per beat and exactly one result beat comes out for it,
// in order. A sample is registered on acceptance, evaluated against the thresholds
// and the escalation state and written to the result register; a new sample can be
// taken every cycle unless the input side stalls. The result and input registers
// form a two-stage pipeline: the input side stalls only while both stages hold data
// and the result side is stalled. Timestamps are in milliseconds modulo 2^32; a
// start time of zero means "not armed". Configuration is to be written by the user
// through the plain write port while no sample is in flight; this is not enforced.
module zone_alarm_escalation_fsm_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    // Sample channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_gas_level,
    input  logic               i_gas_valid,
    input  logic signed [11:0] i_temperature,
    input  logic               i_temp_valid,
    input  logic               i_flame_seen,
    input  logic [31:0]        i_now_ms,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_zone_state,
    output logic [1:0]         o_prior_state,
    output logic               o_state_changed,
    output logic               o_buzzer_on,
    output logic               o_relay_on,
    output logic [7:0]         o_reason_bits,
    output logic [3:0]         o_reason_code,
    output logic [3:0]         o_transition_code,
    output logic [31:0]        o_alarm_start_ms,
    output logic [31:0]        o_linkage_start_ms,
    output logic [31:0]        o_last_change_ms
);
    import zae_pkg::*;

    t_cfg    cfg;
    t_reason reason;
    t_result result;

    logic               r_in_vld;
    logic [15:0]        r_gas_level;
    logic               r_gas_valid;
    logic signed [11:0] r_temperature;
    logic               r_temp_valid;
    logic               r_flame_seen;
    logic [31:0]        r_now_ms;
    logic               r_out_vld;
    t_result            r_result;

    logic step;
    logic in_take;

    // Pipeline control: stage two loads when its register is free or being drained.
    assign step    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !step;

    zae_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_gas_level   <= i_gas_level;
            r_gas_valid   <= i_gas_valid;
            r_temperature <= i_temperature;
            r_temp_valid  <= i_temp_valid;
            r_flame_seen  <= i_flame_seen;
            r_now_ms      <= i_now_ms;
        end
    end

    zae_classify u_classify (
        .i_gas_level   (r_gas_level),
        .i_gas_valid   (r_gas_valid),
        .i_temperature (r_temperature),
        .i_temp_valid  (r_temp_valid),
        .i_flame_seen  (r_flame_seen),
        .i_cfg         (cfg),
        .o_reason      (reason)
    );

    zae_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_reason (reason),
        .i_now_ms (r_now_ms),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= result;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_zone_state       = r_result.zone_state;
    assign o_prior_state      = r_result.prior_state;
    assign o_state_changed    = r_result.state_changed;
    assign o_buzzer_on        = r_result.buzzer_on;
    assign o_relay_on         = r_result.relay_on;
    assign o_reason_bits      = r_result.reason_bits;
    assign o_reason_code      = r_result.reason_code;
    assign o_transition_code  = r_result.transition_code;
    assign o_alarm_start_ms   = r_result.alarm_start_ms;
    assign o_linkage_start_ms = r_result.linkage_start_ms;
    assign o_last_change_ms   = r_result.last_change_ms;

endmodule

>>> rtl/zae_checker.sv
// Port-level checks on the result channel, bound to the top level.
module zae_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_zone_state,
    input logic [1:0] o_prior_state,
    input logic       o_state_changed,
    input logic       o_buzzer_on,
    input logic       o_relay_on
);
    import zae_pkg::*;

    logic [1:0] r_last_state;

    // Zone state of the last delivered beat; reset leaves the zone normal.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_state <= ST_NORMAL;
        end else if (o_out_valid && !i_out_stall) begin
            r_last_state <= o_zone_state;
        end
    end

    // Each beat's prior state is the state reported by the beat before it.
    a_prior_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_prior_state == r_last_state))
        else $error("prior state does not follow the previous beat");

    // The change flag matches the two reported states.
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_state_changed == (o_zone_state != o_prior_state)))
        else $error("state_changed disagrees with the states");

    // Buzzer and relay decode the zone state.
    a_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_relay_on == (o_zone_state == ST_LINKAGE)) &&
                         (o_buzzer_on == ((o_zone_state == ST_ALARM) ||
                                          (o_zone_state == ST_LINKAGE)))))
        else $error("buzzer or relay does not match the zone state");

    // A stalled result beat stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_zone_state) &&
                                          $stable(o_prior_state)))
        else $error("stalled result beat changed");

endmodule

bind zone_alarm_escalation_fsm_unit zae_checker u_zae_checker (.*);

>>> tb/sv/zae_escalation_checker.sv
// Checker for the zone alarm escalation block: predicts each result beat and compares it.
`timescale 1ns / 1ps

module zae_escalation_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [15:0]        i_gas_level,
    input  logic               i_gas_valid,
    input  logic signed [11:0] i_temperature,
    input  logic               i_temp_valid,
    input  logic               i_flame_seen,
    input  logic [31:0]        i_now_ms,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_zone_state,
    input  logic [1:0]         i_prior_state,
    input  logic               i_state_changed,
    input  logic               i_buzzer_on,
    input  logic               i_relay_on,
    input  logic [7:0]         i_reason_bits,
    input  logic [3:0]         i_reason_code,
    input  logic [3:0]         i_transition_code,
    input  logic [31:0]        i_alarm_start_ms,
    input  logic [31:0]        i_linkage_start_ms,
    input  logic [31:0]        i_last_change_ms,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_linkage_beats
);

    import zae_pkg::*;

    localparam int MAX_REPORTED = 40;

    // Threshold and timing registers as the block should hold them.
    logic [15:0]        thr_gas_warn;
    logic [15:0]        thr_gas_alarm;
    logic signed [11:0] thr_temp_warn;
    logic signed [11:0] thr_temp_alarm;
    logic [31:0]        warn_persist;
    logic [31:0]        alarm_persist;
    logic [31:0]        relay_hold;

    // Escalation state of the zone.
    t_zone_state  zone_now;
    logic [31:0]  warn_since;
    logic [31:0]  alarm_since;
    logic [31:0]  link_since;
    logic [31:0]  changed_at;
    t_reason_code last_code;

    // Results still owed by the block, oldest first.
    t_result zone_results[$];
    t_result want;

    // Evaluates one sample against the thresholds and advances the escalation state.
    function automatic t_result escalate(input logic [15:0] gas, input logic gas_ok,
                                         input logic signed [11:0] temp, input logic temp_ok,
                                         input logic flame, input logic [31:0] now);
        logic         gw, ga, tw, ta, warn, alarm, hold, persisted;
        logic [7:0]   bits;
        logic [31:0]  link_age, alarm_age, warn_age;
        t_zone_state  prev, nxt;
        t_reason_code code;
        t_result      r;
        gw = gas_ok && (gas >= thr_gas_warn);
        ga = gas_ok && (gas >= thr_gas_alarm);
        tw = temp_ok && (temp >= thr_temp_warn);
        ta = temp_ok && (temp >= thr_temp_alarm);
        warn = gw || tw;
        alarm = flame || ga || ta || (gw && tw);

        bits = '0;
        bits[RB_GASWARN] = gw;
        bits[RB_TEMPWARN] = tw;
        bits[RB_GASALARM] = ga;
        bits[RB_TEMPALARM] = ta;
        bits[RB_FLAME] = flame;
        bits[RB_COMBINED] = gw && tw;

        // Start times are armed by the first sample of a condition and cleared when it ends.
        // Arming at time zero leaves the start unarmed.
        if (!warn) begin
            warn_since = '0;
        end else if (warn_since == '0) begin
            warn_since = now;
        end
        if (!alarm) begin
            alarm_since = '0;
        end else if (alarm_since == '0) begin
            alarm_since = now;
        end

        link_age = now - link_since;
        alarm_age = now - alarm_since;
        warn_age = now - warn_since;
        hold = (zone_now == ST_LINKAGE) && !alarm && (link_since != '0) &&
               (link_age < relay_hold);
        persisted = alarm && (alarm_since != '0) && (alarm_age >= alarm_persist);

        // Next state: relay hold wins, then alarm or linkage, then a persisting warning.
        nxt = ST_NORMAL;
        if (hold) begin
            nxt = ST_LINKAGE;
            bits[RB_HOLD] = 1'b1;
        end else if (alarm) begin
            nxt = persisted ? ST_LINKAGE : ST_ALARM;
            bits[RB_PERSISTED] = persisted;
        end else if (warn && (warn_since != '0) && (warn_age >= warn_persist)) begin
            nxt = ST_WARNING;
        end

        // Highest-priority reason among the set bits.
        if (bits[RB_HOLD]) code = RC_HOLD;
        else if (bits[RB_PERSISTED]) code = RC_PERSISTED;
        else if (bits[RB_FLAME]) code = RC_FLAME;
        else if (bits[RB_GASALARM]) code = RC_GAS;
        else if (bits[RB_TEMPALARM]) code = RC_TEMP;
        else if (bits[RB_COMBINED]) code = RC_COMBINED;
        else if (bits[RB_GASWARN]) code = RC_GASWARN;
        else if (bits[RB_TEMPWARN]) code = RC_TEMPWARN;
        else code = RC_CLEAR;

        prev = zone_now;
        zone_now = nxt;

        // Linkage start is taken on entry and dropped once linkage is fully over.
        if (nxt == ST_LINKAGE && prev != ST_LINKAGE) begin
            link_since = now;
        end else if (nxt != ST_LINKAGE && !hold && !alarm) begin
            link_since = '0;
        end
        if (nxt != prev) begin
            changed_at = now;
            last_code = code;
        end

        r.zone_state = nxt;
        r.prior_state = prev;
        r.state_changed = (nxt != prev);
        r.buzzer_on = (nxt == ST_ALARM) || (nxt == ST_LINKAGE);
        r.relay_on = (nxt == ST_LINKAGE);
        r.reason_bits = bits;
        r.reason_code = code;
        r.transition_code = last_code;
        r.alarm_start_ms = alarm_since;
        r.linkage_start_ms = link_since;
        r.last_change_ms = changed_at;
        return r;
    endfunction

    // Prints one mismatch line while the log is short, and always counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTED) begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, exp_val);
        end
    endtask

    // Watch the write port and both channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_gas_warn = RST_GAS_WARN;
            thr_gas_alarm = RST_GAS_ALARM;
            thr_temp_warn = RST_TEMP_WARN;
            thr_temp_alarm = RST_TEMP_ALARM;
            warn_persist = RST_WARN_PERSIST;
            alarm_persist = RST_ALARM_PERSIST;
            relay_hold = RST_RELAY_HOLD;
            zone_now = ST_NORMAL;
            warn_since = '0;
            alarm_since = '0;
            link_since = '0;
            changed_at = '0;
            last_code = RC_INIT;
            zone_results.delete();
            o_mismatches = 0;
            o_pending = 0;
            o_checked = 0;
            o_linkage_beats = 0;
        end else begin
            // Register writes; an index past the last register is ignored.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAS_WARN: thr_gas_warn = i_cfg_wdata[15:0];
                    CFG_GAS_ALARM: thr_gas_alarm = i_cfg_wdata[15:0];
                    CFG_TEMP_WARN: thr_temp_warn = i_cfg_wdata[11:0];
                    CFG_TEMP_ALARM: thr_temp_alarm = i_cfg_wdata[11:0];
                    CFG_WARN_PERSIST: warn_persist = i_cfg_wdata;
                    CFG_ALARM_PERSIST: alarm_persist = i_cfg_wdata;
                    CFG_RELAY_HOLD: relay_hold = i_cfg_wdata;
                    default: ;
                endcase
            end

            // Result beat: compare with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (zone_results.size() == 0) begin
                    report_mismatch("result beat with no sample outstanding",
                                    32'(i_zone_state), '0);
                end else begin
                    want = zone_results.pop_front();
                    o_pending--;
                    o_checked++;
                    if (want.zone_state == ST_LINKAGE) o_linkage_beats++;
                    if (i_zone_state !== want.zone_state)
                        report_mismatch("zone_state", 32'(i_zone_state),
                                        32'(want.zone_state));
                    if (i_prior_state !== want.prior_state)
                        report_mismatch("prior_state", 32'(i_prior_state),
                                        32'(want.prior_state));
                    if (i_state_changed !== want.state_changed)
                        report_mismatch("state_changed", 32'(i_state_changed),
                                        32'(want.state_changed));
                    if (i_buzzer_on !== want.buzzer_on)
                        report_mismatch("buzzer_on", 32'(i_buzzer_on), 32'(want.buzzer_on));
                    if (i_relay_on !== want.relay_on)
                        report_mismatch("relay_on", 32'(i_relay_on), 32'(want.relay_on));
                    if (i_reason_bits !== want.reason_bits)
                        report_mismatch("reason_bits", 32'(i_reason_bits),
                                        32'(want.reason_bits));
                    if (i_reason_code !== want.reason_code)
                        report_mismatch("reason_code", 32'(i_reason_code),
                                        32'(want.reason_code));
                    if (i_transition_code !== want.transition_code)
                        report_mismatch("transition_code", 32'(i_transition_code),
                                        32'(want.transition_code));
                    if (i_alarm_start_ms !== want.alarm_start_ms)
                        report_mismatch("alarm_start_ms", i_alarm_start_ms,
                                        want.alarm_start_ms);
                    if (i_linkage_start_ms !== want.linkage_start_ms)
                        report_mismatch("linkage_start_ms", i_linkage_start_ms,
                                        want.linkage_start_ms);
                    if (i_last_change_ms !== want.last_change_ms)
                        report_mismatch("last_change_ms", i_last_change_ms,
                                        want.last_change_ms);
                end
            end

            // Sample beat: predict its result.
            if (i_in_valid && !i_in_stall) begin
                zone_results.push_back(escalate(i_gas_level, i_gas_valid, i_temperature,
                                                i_temp_valid, i_flame_seen, i_now_ms));
                o_pending++;
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the zone alarm escalation block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    import zae_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY_CYCLES = 4;
    localparam int END_CYCLES = 8;
    localparam int HOLDOFF_AFTER = 40;
    localparam int HOLDOFF_CYCLES = 120;
    localparam logic [2:0] CFG_BAD_IDX = 3'd7;

    // Receiver stall patterns.
    localparam int RX_FREE = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;
    localparam int RX_HOLDOFF = 3;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        gas_level;
    logic               gas_valid;
    logic signed [11:0] temperature;
    logic               temp_valid;
    logic               flame_seen;
    logic [31:0]        now_ms;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         zone_state;
    logic [1:0]         prior_state;
    logic               state_changed;
    logic               buzzer_on;
    logic               relay_on;
    logic [7:0]         reason_bits;
    logic [3:0]         reason_code;
    logic [3:0]         transition_code;
    logic [31:0]        alarm_start_ms;
    logic [31:0]        linkage_start_ms;
    logic [31:0]        last_change_ms;

    int mismatches;
    int pending;
    int checked;
    int linkage_beats;

    // Sender bookkeeping and the thresholds last written, used to aim samples.
    int          items_sent;
    int          burst_left;
    int          sh_gas_warn;
    int          sh_gas_alarm;
    int          sh_temp_warn;
    int          sh_temp_alarm;
    logic [31:0] sample_ms;

    zone_alarm_escalation_fsm_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_gas_level       (gas_level),
        .i_gas_valid       (gas_valid),
        .i_temperature     (temperature),
        .i_temp_valid      (temp_valid),
        .i_flame_seen      (flame_seen),
        .i_now_ms          (now_ms),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_zone_state      (zone_state),
        .o_prior_state     (prior_state),
        .o_state_changed   (state_changed),
        .o_buzzer_on       (buzzer_on),
        .o_relay_on        (relay_on),
        .o_reason_bits     (reason_bits),
        .o_reason_code     (reason_code),
        .o_transition_code (transition_code),
        .o_alarm_start_ms  (alarm_start_ms),
        .o_linkage_start_ms(linkage_start_ms),
        .o_last_change_ms  (last_change_ms)
    );

    zae_escalation_checker zone_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_gas_level       (gas_level),
        .i_gas_valid       (gas_valid),
        .i_temperature     (temperature),
        .i_temp_valid      (temp_valid),
        .i_flame_seen      (flame_seen),
        .i_now_ms          (now_ms),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_zone_state      (zone_state),
        .i_prior_state     (prior_state),
        .i_state_changed   (state_changed),
        .i_buzzer_on       (buzzer_on),
        .i_relay_on        (relay_on),
        .i_reason_bits     (reason_bits),
        .i_reason_code     (reason_code),
        .i_transition_code (transition_code),
        .i_alarm_start_ms  (alarm_start_ms),
        .i_linkage_start_ms(linkage_start_ms),
        .i_last_change_ms  (last_change_ms),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_linkage_beats   (linkage_beats)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Returns a value within spread of center, kept inside [lo, hi].
    function automatic int near(input int center, input int spread, input int lo, input int hi);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // One register write, from one falling edge to the next.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Writes all seven registers, optionally with junk above each threshold field, plus a stray write.
    task automatic load_thresholds(input int gw, input int ga, input int tw, input int ta,
                                   input logic [31:0] wp, input logic [31:0] ap,
                                   input logic [31:0] rh, input bit junk);
        logic [31:0] hi;
        logic [15:0] g16;
        logic [11:0] t12;
        hi = junk ? $urandom : 32'd0;
        g16 = 16'(gw);
        write_reg(CFG_GAS_WARN, {hi[31:16], g16});
        g16 = 16'(ga);
        write_reg(CFG_GAS_ALARM, {hi[31:16], g16});
        t12 = 12'(tw);
        write_reg(CFG_TEMP_WARN, {hi[31:12], t12});
        t12 = 12'(ta);
        write_reg(CFG_TEMP_ALARM, {hi[31:12], t12});
        write_reg(CFG_WARN_PERSIST, wp);
        write_reg(CFG_ALARM_PERSIST, ap);
        write_reg(CFG_RELAY_HOLD, rh);
        write_reg(CFG_BAD_IDX, $urandom);
        sh_gas_warn = gw;
        sh_gas_alarm = ga;
        sh_temp_warn = tw;
        sh_temp_alarm = ta;
    endtask

    // Stops sending and waits until every result is back and the pipeline is empty.
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    // Offers one sample beat in bursts with random gaps and waits until it is taken.
    task automatic send_sample(input logic [15:0] gas, input logic gas_ok,
                               input logic signed [11:0] temp, input logic temp_ok,
                               input logic flame, input logic [31:0] now);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        gas_level = gas;
        gas_valid = gas_ok;
        temperature = temp;
        temp_valid = temp_ok;
        flame_seen = flame;
        now_ms = now;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Episodes of steady readings near the thresholds with time moving forward,
    // mixed with fully random samples.
    task automatic run_phase(input int n_items, input int step_max);
        int   done, ep_len, k, gas_base, temp_base;
        logic fl, flip;
        done = 0;
        while (done < n_items) begin
            ep_len = $urandom_range(1, 12);
            case ($urandom_range(0, 4))
                0: gas_base = sh_gas_warn;
                1: gas_base = sh_gas_alarm;
                2: gas_base = $urandom_range(0, 65535);
                3: gas_base = 0;
                default: gas_base = $urandom_range(0, sh_gas_warn);
            endcase
            case ($urandom_range(0, 4))
                0: temp_base = sh_temp_warn;
                1: temp_base = sh_temp_alarm;
                2: temp_base = int'($urandom_range(0, 1650)) - 400;
                3: temp_base = ($urandom_range(0, 1) == 0) ? -400 : 1250;
                default: temp_base = near(sh_temp_warn - 100, 100, -400, 1250);
            endcase
            fl = ($urandom_range(0, 6) == 0);
            for (k = 0; k < ep_len && done < n_items; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_sample(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                                12'(int'($urandom_range(0, 1650)) - 400),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
                end else begin
                    // Mostly steady time steps; now and then a repeat, a wild jump or zero.
                    case ($urandom_range(0, 19))
                        0: ;
                        1: sample_ms = $urandom;
                        2: sample_ms = '0;
                        3, 4, 5: sample_ms = sample_ms + $urandom_range(0, 4 * step_max);
                        default: sample_ms = sample_ms + $urandom_range(1, step_max);
                    endcase
                    flip = ($urandom_range(0, 19) == 0);
                    send_sample(16'(near(gas_base, 6, 0, 65535)), $urandom_range(0, 11) != 0,
                                12'(near(temp_base, 6, -400, 1250)),
                                $urandom_range(0, 11) != 0, fl ^ flip, sample_ms);
                end
                done++;
            end
        end
    endtask

    // Receiver: stall patterns in random segments, and one long hold-off early on.
    initial begin : receiver
        int seg_len, mode, k;
        bit held_off;
        out_stall = 1'b0;
        held_off = 1'b0;
        forever begin
            seg_len = $urandom_range(10, 80);
            mode = $urandom_range(RX_FREE, RX_HEAVY);
            if (!held_off && items_sent >= HOLDOFF_AFTER) begin
                held_off = 1'b1;
                mode = RX_HOLDOFF;
                seg_len = HOLDOFF_CYCLES;
            end
            for (k = 0; k < seg_len; k++) begin
                @(negedge i_clk);
                case (mode)
                    RX_FREE: out_stall = 1'b0;
                    RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
                    default: out_stall = 1'b1;
                endcase
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Main stimulus.
    initial begin : stimulus
        int gw, ga, tw, ta;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        gas_level = '0;
        gas_valid = 1'b0;
        temperature = '0;
        temp_valid = 1'b0;
        flame_seen = 1'b0;
        now_ms = '0;
        items_sent = 0;
        burst_left = 0;
        sample_ms = '0;
        sh_gas_warn = int'(RST_GAS_WARN);
        sh_gas_alarm = int'(RST_GAS_ALARM);
        sh_temp_warn = int'(RST_TEMP_WARN);
        sh_temp_alarm = int'(RST_TEMP_ALARM);
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on reset thresholds: extremes, each reason, arming at time zero,
        // persistence into linkage, relay hold and its expiry, invalid readings.
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd0);
        send_sample(16'hFFFF, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd0);
        send_sample(16'hFFFF, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd6000);
        send_sample(16'hFFFF, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd11000);
        send_sample(16'hFFFF, 1'b0, 12'sd1250, 1'b0, 1'b0, 32'd12000);
        send_sample(16'hFFFF, 1'b0, 12'sd1250, 1'b0, 1'b0, 32'd21000);
        send_sample(16'd0, 1'b1, -12'sd400, 1'b1, 1'b0, 32'd21001);
        send_sample(16'd0, 1'b1, 12'sd1250, 1'b1, 1'b0, 32'd22000);
        send_sample(16'd300, 1'b1, 12'sd450, 1'b1, 1'b0, 32'd23000);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b1, 32'd24000);
        send_sample(16'd300, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd25000);
        send_sample(16'd300, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd28000);
        send_sample(16'd0, 1'b1, 12'sd450, 1'b1, 1'b0, 32'd28500);
        send_sample(16'd0, 1'b0, 12'sd0, 1'b0, 1'b0, 32'd29000);

        // Zero relay hold, a stray register index, then a wrapped alarm age.
        settle();
        write_reg(CFG_RELAY_HOLD, 32'd0);
        write_reg(CFG_BAD_IDX, 32'hFFFF_FFFF);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b1, 32'd30000);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b1, 32'd35000);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b0, 32'd35001);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b1, 32'hFFFF_F000);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b1, 32'h0000_0500);
        send_sample(16'd0, 1'b1, 12'sd0, 1'b1, 1'b0, 32'h0000_0600);
        send_sample(16'd599, 1'b1, 12'sd599, 1'b1, 1'b0, 32'h0000_0700);
        send_sample(16'd600, 1'b1, 12'sd449, 1'b1, 1'b0, 32'h0000_0800);

        // Random part over several threshold settings: reset values, then extremes, then random ones.
        settle();
        load_thresholds(300, 600, 450, 600, 32'd3000, 32'd5000, 32'd10000, 1'b0);
        sample_ms = 32'd1000;
        run_phase(180, 1500);

        settle();
        load_thresholds(0, 65535, -400, 1250, 32'd0, 32'd0, 32'd0, 1'b0);
        run_phase(180, 40);

        settle();
        load_thresholds(65535, 0, 1250, -400, '1, '1, '1, 1'b1);
        run_phase(120, 2000);

        repeat (2) begin
            settle();
            gw = $urandom_range(50, 800);
            ga = gw + int'($urandom_range(0, 800));
            tw = int'($urandom_range(0, 900)) - 400;
            ta = tw + int'($urandom_range(0, 600));
            if (ta > 1250) ta = 1250;
            load_thresholds(gw, ga, tw, ta, $urandom_range(0, 3000), $urandom_range(0, 5000),
                            $urandom_range(0, 8000), 1'b1);
            run_phase(135, 1500);
        end

        // Drain and give the verdict.
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (END_CYCLES) @(negedge i_clk);
        $display("Run covered %0d samples over six threshold settings, with wrapped and zero",
                 items_sent);
        $display("timestamps; %0d results checked, %0d in linkage, %0d mismatches.",
                 checked, linkage_beats, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
